// ----- rtl/dsrs_pkg.sv -----
package dsrs_pkg;

  localparam int INTERVAL_W = 14;
  localparam int REQ_W      = 16;
  localparam int LEN_W      = 16;
  localparam int COUNT_W    = 32;
  localparam int PROD_W     = INTERVAL_W + LEN_W;

  localparam logic [INTERVAL_W-1:0] MIN_INTERVAL     = INTERVAL_W'(500);
  localparam logic [INTERVAL_W-1:0] MAX_INTERVAL     = INTERVAL_W'(10000);
  localparam logic [INTERVAL_W-1:0] DEFAULT_INTERVAL = INTERVAL_W'(2000);

  // item kinds
  localparam logic [2:0] KIND_TICK     = 3'd0;
  localparam logic [2:0] KIND_SET_CMD  = 3'd1;
  localparam logic [2:0] KIND_SET_NOW  = 3'd2;
  localparam logic [2:0] KIND_RAMP_TO  = 3'd3;
  localparam logic [2:0] KIND_SMOOTH   = 3'd4;
  localparam logic [2:0] KIND_CLEAR    = 3'd5;

  // motion commands
  localparam logic [2:0] CMD_STOP = 3'd0;
  localparam logic [2:0] CMD_FWD  = 3'd1;
  localparam logic [2:0] CMD_BACK = 3'd2;
  localparam logic [2:0] CMD_CW   = 3'd3;
  localparam logic [2:0] CMD_CCW  = 3'd4;

  // per-motor direction
  localparam logic [1:0] DIR_NONE = 2'd0;
  localparam logic [1:0] DIR_FWD  = 2'd1;
  localparam logic [1:0] DIR_BACK = 2'd2;

  typedef struct packed {
    logic [2:0]       kind;
    logic [2:0]       command;
    logic [REQ_W-1:0] interval_request;
  } in_item_t;

  typedef struct packed {
    logic [3:0]                coils_a;
    logic [3:0]                coils_b;
    logic [INTERVAL_W-1:0]     step_interval;
    logic signed [COUNT_W-1:0] step_count;
    logic                      moving;
    logic                      ramping;
  } out_item_t;

  typedef struct packed {
    logic exec;
    logic mul;
    logic div_load;
    logic div_step;
    logic commit;
    logic out_load;
  } dsrs_cmd_t;

  typedef struct packed {
    logic need_div;
    logic div_last;
  } dsrs_stat_t;

  function automatic logic [INTERVAL_W-1:0] clamp_interval(input logic [REQ_W-1:0] req);
    logic [INTERVAL_W-1:0] v;
    if (req < REQ_W'(MIN_INTERVAL)) begin
      v = MIN_INTERVAL;
    end else if (req > REQ_W'(MAX_INTERVAL)) begin
      v = MAX_INTERVAL;
    end else begin
      v = req[INTERVAL_W-1:0];
    end
    return v;
  endfunction

  function automatic logic [1:0] motor_dir(input logic [2:0] cmd, input logic sel_b);
    logic [1:0] d;
    case (cmd)
      CMD_FWD:  d = DIR_FWD;
      CMD_BACK: d = DIR_BACK;
      CMD_CW:   d = sel_b ? DIR_BACK : DIR_FWD;
      CMD_CCW:  d = sel_b ? DIR_FWD : DIR_BACK;
      default:  d = DIR_NONE;
    endcase
    return d;
  endfunction

  function automatic logic [2:0] step_phase(input logic [2:0] ph, input logic [1:0] dir);
    logic [2:0] p;
    case (dir)
      DIR_FWD:  p = ph + 3'd1;
      DIR_BACK: p = ph - 3'd1;
      default:  p = ph;
    endcase
    return p;
  endfunction

  // eight-phase half-step coil pattern
  function automatic logic [3:0] half_step_coils(input logic [2:0] ph);
    logic [3:0] c;
    case (ph)
      3'd0:    c = 4'h1;
      3'd1:    c = 4'h3;
      3'd2:    c = 4'h2;
      3'd3:    c = 4'h6;
      3'd4:    c = 4'h4;
      3'd5:    c = 4'hC;
      3'd6:    c = 4'h8;
      3'd7:    c = 4'h9;
      default: c = 4'h0;
    endcase
    return c;
  endfunction

endpackage

// ----- rtl/dsrs_ctrl.sv -----
module dsrs_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  output logic                out_valid,
  input  logic                out_stall,
  input  dsrs_pkg::dsrs_stat_t stat,
  output dsrs_pkg::dsrs_cmd_t  cmd
);
  import dsrs_pkg::*;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_MUL    = 3'd1;
  localparam logic [2:0] ST_LOAD   = 3'd2;
  localparam logic [2:0] ST_DIV    = 3'd3;
  localparam logic [2:0] ST_COMMIT = 3'd4;
  localparam logic [2:0] ST_RESP   = 3'd5;

  logic [2:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;

  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.exec  = 1'b1;
          state_nxt = stat.need_div ? ST_MUL : ST_RESP;
        end
      end
      ST_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = ST_LOAD;
      end
      ST_LOAD: begin
        cmd.div_load = 1'b1;
        state_nxt    = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_last) begin
          state_nxt = ST_COMMIT;
        end
      end
      ST_COMMIT: begin
        cmd.commit = 1'b1;
        state_nxt  = ST_RESP;
      end
      ST_RESP: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_valid_nxt = cmd.out_load ? 1'b1 : (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

`ifndef SYNTHESIS
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid_r || !out_stall))
    else $error("result register overwritten while held");

  a_short_path: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE && in_valid && !stat.need_div) |=> (state_r == ST_RESP))
    else $error("simple item did not go straight to result");

  a_div_end: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV && stat.div_last) |=> (state_r == ST_COMMIT))
    else $error("divider end not followed by commit");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |=> out_valid_r)
    else $error("held result dropped");
`endif

endmodule

// ----- rtl/dsrs_datapath.sv -----
module dsrs_datapath (
  input  logic                 clk,
  input  logic                 rst_n,
  input  dsrs_pkg::in_item_t   in_data,
  input  logic                 cfg_we,
  input  logic [15:0]          cfg_data,
  input  dsrs_pkg::dsrs_cmd_t  cmd,
  output dsrs_pkg::dsrs_stat_t stat,
  output dsrs_pkg::out_item_t  out_data
);
  import dsrs_pkg::*;

  localparam logic [3:0] DIV_LAST_CNT = 4'(INTERVAL_W - 1);

  logic [LEN_W-1:0]        ramp_length_r;
  logic [2:0]              motion_r;
  logic [2:0]              phase_a_r, phase_b_r;
  logic [3:0]              coils_a_r, coils_b_r;
  logic [INTERVAL_W-1:0]   interval_r, ramp_from_r, ramp_to_r;
  logic [LEN_W-1:0]        ramp_ticks_r;
  logic                    ramp_active_r, stop_after_r;
  logic signed [COUNT_W-1:0] total_r;

  logic [PROD_W-1:0]       product_r;
  logic [LEN_W-1:0]        rem_r;
  logic [INTERVAL_W-1:0]   dvd_r, quot_r;
  logic [3:0]              cnt_r;
  out_item_t               out_r;

  logic [LEN_W-1:0]        ticks_inc;
  logic                    ramp_end, is_tick, ramp_stop, down;
  logic [2:0]              cmd_eff, cmd_clip;
  logic [1:0]              dir_a, dir_b;
  logic [2:0]              phase_a_nxt, phase_b_nxt;
  logic [INTERVAL_W-1:0]   req_clamped, diff;
  logic [LEN_W:0]          rem_sh, rem_sub;
  logic                    rem_ge;

  assign is_tick   = (in_data.kind == KIND_TICK);
  assign ticks_inc = ramp_ticks_r + LEN_W'(1);
  assign ramp_end  = (ticks_inc == '0) || (ticks_inc >= ramp_length_r);
  // ramp finishing on this tick with a pending smooth stop: no step
  assign ramp_stop = ramp_active_r && ramp_end && stop_after_r;
  assign cmd_eff   = ramp_stop ? CMD_STOP : motion_r;
  assign dir_a     = motor_dir(cmd_eff, 1'b0);
  assign dir_b     = motor_dir(cmd_eff, 1'b1);
  assign phase_a_nxt = step_phase(phase_a_r, dir_a);
  assign phase_b_nxt = step_phase(phase_b_r, dir_b);
  assign req_clamped = clamp_interval(in_data.interval_request);
  assign cmd_clip  = (in_data.command inside {[CMD_STOP:CMD_CCW]}) ? in_data.command : CMD_STOP;

  assign down = (ramp_from_r > ramp_to_r);
  assign diff = down ? (ramp_from_r - ramp_to_r) : (ramp_to_r - ramp_from_r);

  // restoring divider step
  assign rem_sh  = {rem_r, dvd_r[INTERVAL_W-1]};
  assign rem_ge  = (rem_sh >= {1'b0, ramp_length_r});
  assign rem_sub = rem_sh - {1'b0, ramp_length_r};

  assign stat.need_div = is_tick && ramp_active_r && !ramp_end;
  assign stat.div_last = (cnt_r == '0);
  assign out_data      = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ramp_length_r <= '0;
      motion_r      <= CMD_STOP;
      phase_a_r     <= '0;
      phase_b_r     <= '0;
      coils_a_r     <= '0;
      coils_b_r     <= '0;
      interval_r    <= DEFAULT_INTERVAL;
      ramp_from_r   <= DEFAULT_INTERVAL;
      ramp_to_r     <= DEFAULT_INTERVAL;
      ramp_ticks_r  <= '0;
      ramp_active_r <= 1'b0;
      stop_after_r  <= 1'b0;
      total_r       <= '0;
    end else begin
      if (cfg_we) begin
        ramp_length_r <= cfg_data;
      end
      if (cmd.exec) begin
        case (in_data.kind)
          KIND_TICK: begin
            if (ramp_active_r) begin
              if (ramp_end) begin
                interval_r    <= ramp_to_r;
                ramp_active_r <= 1'b0;
                ramp_ticks_r  <= '0;
                if (stop_after_r) begin
                  stop_after_r <= 1'b0;
                  motion_r     <= CMD_STOP;
                end
              end else begin
                ramp_ticks_r <= ticks_inc;
              end
            end
            if (dir_a != DIR_NONE) begin
              phase_a_r <= phase_a_nxt;
              coils_a_r <= half_step_coils(phase_a_nxt);
              total_r   <= (dir_a == DIR_FWD) ? total_r + 32'sd1 : total_r - 32'sd1;
            end
            if (dir_b != DIR_NONE) begin
              phase_b_r <= phase_b_nxt;
              coils_b_r <= half_step_coils(phase_b_nxt);
            end
          end
          KIND_SET_CMD: begin
            motion_r <= cmd_clip;
            if (cmd_clip == CMD_STOP) begin
              coils_a_r <= '0;
              coils_b_r <= '0;
            end
          end
          KIND_SET_NOW: begin
            interval_r <= req_clamped;
          end
          KIND_RAMP_TO: begin
            if (ramp_length_r == '0) begin
              interval_r <= req_clamped;
            end else begin
              ramp_to_r    <= req_clamped;
              ramp_ticks_r <= '0;
              if (interval_r != req_clamped) begin
                ramp_from_r   <= interval_r;
                ramp_active_r <= 1'b1;
              end
            end
          end
          KIND_SMOOTH: begin
            if (ramp_length_r == '0 || motion_r == CMD_STOP) begin
              motion_r  <= CMD_STOP;
              coils_a_r <= '0;
              coils_b_r <= '0;
            end else begin
              stop_after_r  <= 1'b1;
              ramp_from_r   <= interval_r;
              ramp_to_r     <= MAX_INTERVAL;
              ramp_ticks_r  <= '0;
              ramp_active_r <= 1'b1;
            end
          end
          KIND_CLEAR: begin
            total_r <= '0;
          end
          default: begin
          end
        endcase
      end
      if (cmd.commit) begin
        interval_r <= down ? (ramp_from_r - quot_r) : (ramp_from_r + quot_r);
      end
    end
  end

  // interpolation: |to - from| * ticks / length, quotient fits the interval width
  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      product_r <= PROD_W'(diff) * PROD_W'(ramp_ticks_r);
    end
    if (cmd.div_load) begin
      rem_r  <= product_r[PROD_W-1:INTERVAL_W];
      dvd_r  <= product_r[INTERVAL_W-1:0];
      quot_r <= '0;
      cnt_r  <= DIV_LAST_CNT;
    end else if (cmd.div_step) begin
      rem_r  <= rem_ge ? rem_sub[LEN_W-1:0] : rem_sh[LEN_W-1:0];
      dvd_r  <= {dvd_r[INTERVAL_W-2:0], 1'b0};
      quot_r <= {quot_r[INTERVAL_W-2:0], rem_ge};
      cnt_r  <= cnt_r - 4'd1;
    end
    if (cmd.out_load) begin
      out_r.coils_a       <= coils_a_r;
      out_r.coils_b       <= coils_b_r;
      out_r.step_interval <= interval_r;
      out_r.step_count    <= total_r;
      out_r.moving        <= (motion_r != CMD_STOP);
      out_r.ramping       <= ramp_active_r;
    end
  end

endmodule

// ----- rtl/dual_stepper_ramp_sequencer.sv -----
// channel  dir  handshake          payload
// in_      in   in_valid/in_stall  in_data   (kind, command, interval_request)
// out_     out  out_valid/out_stall out_data (coils, interval, count, flags)
// cfg_     in   cfg_valid/cfg_ready cfg_data (ramp_length)
//
// a simple item goes from accept straight to the result; a tick that interpolates a running ramp
// takes the long path: one multiply plus the 14-step serial restoring divider
// one item at a time; in_stall is high from accept until the result is loaded
// the result register lets the next item start while out_stall holds a result
// rst_n is synchronous, active low; config is taken in any cycle
module dual_stepper_ramp_sequencer (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  dsrs_pkg::in_item_t in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output dsrs_pkg::out_item_t out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [15:0]        cfg_data
);
  import dsrs_pkg::*;

  dsrs_cmd_t  cmd;
  dsrs_stat_t stat;

  // ramp length register is always writable
  assign cfg_ready = 1'b1;

  // sequencing: accept, multiply, divider load, divide, commit, result
  dsrs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  // motor state, ramp state, serial divider and result register
  dsrs_datapath u_datapath (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cfg_we   (cfg_valid && cfg_ready),
    .cfg_data (cfg_data),
    .cmd      (cmd),
    .stat     (stat),
    .out_data (out_data)
  );

endmodule
